// ===== src/csb_pkg.sv =====
// Package of types and codes for the coalescing store buffer.
package csb_pkg;

  // Buffer geometry that the port widths are built around.
  localparam int ENTRIES   = 16;
  localparam int BLOCK_IDS = 256;

  typedef enum logic [1:0] {
    CMD_STORE = 2'd0,
    CMD_RESP  = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_DRAIN = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    RK_IDLE      = 3'd0,
    RK_MERGED    = 3'd1,
    RK_ALLOC     = 3'd2,
    RK_REFUSED   = 3'd3,
    RK_ISSUED    = 3'd4,
    RK_COMMITTED = 3'd5,
    RK_FREED     = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_ISSUE_OLD,
    ST_DRAIN,
    ST_DONE
  } state_t;

endpackage

// ===== src/coalescing_store_buffer_core.sv =====
// Top level of the coalescing store buffer: entry storage, scan sequencer and result ports.
//
//  channel   | signals                                              | timing
//  ----------+------------------------------------------------------+------------------------
//  request   | start, busy, command and payload ports               | taken when start && !busy
//  result    | result_valid, result_kind ... last_of_run            | each shown for a single cycle
//  config    | cfg_write, cfg_data                                  | written on cfg_write
//
// A request walks the entries with one shared compare unit, one entry per cycle. A store,
// response, drain command or tick without write_ready keeps busy high through the walk
// and a decide step, and no new request is taken until busy falls. A tick with write_ready
// adds an issue step and a closing step, and a second walk of the entries while a drain
// is active. Each issue result is held until the next one is found so the final one can
// carry last_of_run; the last result of a request shows in the first cycle with busy low.
// Reset is synchronous and clears all valid, waiting and seen flags, the tick counter
// and the drain state; entry payload is left as it is. The receiver cannot stall, so
// each result is shown for exactly one cycle and busy stays high until the last one.
module coalescing_store_buffer_core #(
  parameter int LINE_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_write,
  input  logic        cfg_data,
  input  logic [1:0]  command,
  input  logic [31:0] line_address,
  input  logic [7:0]  block_id,
  input  logic [63:0] store_data,
  input  logic [7:0]  byte_mask,
  input  logic        last_of_instruction,
  input  logic [3:0]  response_tag,
  input  logic        upstream_holds_block,
  input  logic        write_ready,
  output logic        result_valid,
  output logic [2:0]  result_kind,
  output logic [3:0]  entry_index,
  output logic [31:0] write_address,
  output logic [63:0] write_data,
  output logic [7:0]  write_mask,
  output logic [7:0]  result_block,
  output logic [4:0]  occupancy,
  output logic        last_of_run
);

  localparam int ENTRIES   = csb_pkg::ENTRIES;
  localparam int BLOCK_IDS = csb_pkg::BLOCK_IDS;
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int BW = (BLOCK_IDS > 1) ? $clog2(BLOCK_IDS) : 1;
  localparam logic [7:0] LANES = (LINE_BYTES >= 8) ? 8'hFF : 8'((1 << LINE_BYTES) - 1);

  // Entry flags live in flip-flops; payload is plain registers without reset.
  logic [ENTRIES-1:0] valid, waiting, from_last;
  logic [31:0] e_addr  [ENTRIES];
  logic [7:0]  e_blk   [ENTRIES];
  logic [63:0] e_data  [ENTRIES];
  logic [7:0]  e_mask  [ENTRIES];
  logic [31:0] e_stamp [ENTRIES];
  logic [BLOCK_IDS-1:0] seen;

  logic [31:0] tick_count;
  logic        drain_active;
  logic [7:0]  drain_block;
  logic        wait_resp;

  // Latched request.
  csb_pkg::cmd_t r_cmd;
  logic [31:0] r_addr;
  logic [7:0]  r_blk;
  logic [63:0] r_data;
  logic [7:0]  r_mask;
  logic        r_last, r_up, r_ready;
  logic [3:0]  r_tag;

  // Scan bookkeeping.
  csb_pkg::state_t state, state_next;
  logic [IW:0] idx;
  logic        hit_f, free_f, old_f, other_f;
  logic [IW-1:0] hit_i, free_i, old_i;
  logic [31:0] best;
  logic [CW-1:0] occ;
  logic [4:0]  n_out;

  // Issue result waiting for the next one, so that the last of a tick is known.
  logic        hold_f;
  logic [3:0]  hold_idx;
  logic [31:0] hold_addr;
  logic [63:0] hold_data;
  logic [7:0]  hold_mask, hold_blk;

  logic [IW-1:0] ci;
  assign ci = idx[IW-1:0];

  function automatic logic [63:0] expand(input logic [7:0] m);
    logic [63:0] r;
    for (int b = 0; b < 8; b++) r[8*b +: 8] = {8{m[b]}};
    return r;
  endfunction

  assign busy = (state != csb_pkg::ST_IDLE);

  // Current walked entry is a drain candidate.
  logic drain_hit;
  assign drain_hit = valid[ci] && !waiting[ci] && (e_blk[ci] == drain_block);

  logic tag_ok;
  assign tag_ok = (32'(r_tag) < ENTRIES) && valid[r_tag[IW-1:0]] && waiting[r_tag[IW-1:0]];

  always_comb begin
    state_next = state;
    case (state)
      csb_pkg::ST_IDLE:   if (start) state_next = csb_pkg::ST_SCAN;
      csb_pkg::ST_SCAN:   if (32'(idx) == ENTRIES - 1) state_next = csb_pkg::ST_DECIDE;
      csb_pkg::ST_DECIDE: begin
        if (r_cmd == csb_pkg::CMD_TICK && r_ready) state_next = csb_pkg::ST_ISSUE_OLD;
        else state_next = csb_pkg::ST_IDLE;
      end
      csb_pkg::ST_ISSUE_OLD: begin
        if (drain_active) state_next = csb_pkg::ST_DRAIN;
        else state_next = csb_pkg::ST_DONE;
      end
      csb_pkg::ST_DRAIN:  if (32'(idx) == ENTRIES - 1) state_next = csb_pkg::ST_DONE;
      csb_pkg::ST_DONE:   state_next = csb_pkg::ST_IDLE;
      default:            state_next = csb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= csb_pkg::ST_IDLE;
      valid <= '0;
      waiting <= '0;
      from_last <= '0;
      seen <= '0;
      tick_count <= '0;
      drain_active <= 1'b0;
      drain_block <= '0;
      wait_resp <= 1'b1;
      result_valid <= 1'b0;
      occ <= '0;
      idx <= '0;
    end else begin
      state <= state_next;
      result_valid <= 1'b0;
      if (cfg_write) wait_resp <= cfg_data;
      case (state)
        csb_pkg::ST_IDLE: begin
          if (start) begin
            r_cmd <= csb_pkg::cmd_t'(command);
            r_addr <= line_address; r_blk <= block_id; r_data <= store_data;
            r_mask <= byte_mask & LANES; r_last <= last_of_instruction;
            r_tag <= response_tag; r_up <= upstream_holds_block; r_ready <= write_ready;
            idx <= '0; hit_f <= 1'b0; free_f <= 1'b0; old_f <= 1'b0;
            other_f <= 1'b0; best <= 32'hFFFF_FFFF;
          end
        end
        csb_pkg::ST_SCAN: begin
          // One entry per cycle through the shared compare unit.
          if (!hit_f && valid[ci] && e_addr[ci] == r_addr) begin
            hit_f <= 1'b1; hit_i <= ci;
          end
          if (!free_f && !valid[ci]) begin
            free_f <= 1'b1; free_i <= ci;
          end
          if (valid[ci] && !waiting[ci] && e_stamp[ci] < best) begin
            best <= e_stamp[ci]; old_f <= 1'b1; old_i <= ci;
          end
          if (32'(r_tag) != 32'(ci) && valid[ci] && e_blk[ci] == e_blk[r_tag[IW-1:0]])
            other_f <= 1'b1;
          idx <= idx + 1'b1;
        end
        csb_pkg::ST_DECIDE: begin
          result_kind <= csb_pkg::RK_IDLE;
          entry_index <= '0;
          write_address <= '0; write_data <= '0; write_mask <= '0;
          result_block <= '0;
          last_of_run <= 1'b1;
          occupancy <= 5'(occ);
          case (r_cmd)
            csb_pkg::CMD_STORE: begin
              result_valid <= 1'b1;
              if (hit_f) begin
                e_data[hit_i] <= (e_data[hit_i] & ~expand(r_mask)) | (r_data & expand(r_mask));
                e_mask[hit_i] <= e_mask[hit_i] | r_mask;
                e_stamp[hit_i] <= tick_count;
                if (r_last) from_last[hit_i] <= 1'b1;
                result_kind <= csb_pkg::RK_MERGED;
                entry_index <= 4'(hit_i);
                result_block <= e_blk[hit_i];
              end else if (free_f) begin
                valid[free_i] <= 1'b1; waiting[free_i] <= 1'b0;
                e_addr[free_i] <= r_addr; e_blk[free_i] <= r_blk;
                e_stamp[free_i] <= tick_count; e_mask[free_i] <= r_mask;
                e_data[free_i] <= r_data & expand(LANES);
                from_last[free_i] <= r_last;
                result_kind <= csb_pkg::RK_ALLOC;
                entry_index <= 4'(free_i);
                result_block <= r_blk;
                occ <= occ + 1'b1;
                occupancy <= 5'(occ + 1'b1);
              end else begin
                result_kind <= csb_pkg::RK_REFUSED;
                result_block <= r_blk;
              end
            end
            csb_pkg::CMD_RESP: begin
              result_valid <= 1'b1;
              if (tag_ok) begin
                valid[r_tag[IW-1:0]] <= 1'b0;
                waiting[r_tag[IW-1:0]] <= 1'b0;
                from_last[r_tag[IW-1:0]] <= 1'b0;
                occ <= occ - 1'b1;
                occupancy <= 5'(occ - 1'b1);
                entry_index <= r_tag;
                result_block <= e_blk[r_tag[IW-1:0]];
                if (wait_resp && !other_f && !r_up && (from_last[r_tag[IW-1:0]] ||
                    seen[BW'(e_blk[r_tag[IW-1:0]] % BLOCK_IDS)])) begin
                  seen[BW'(e_blk[r_tag[IW-1:0]] % BLOCK_IDS)] <= 1'b0;
                  result_kind <= csb_pkg::RK_COMMITTED;
                end else begin
                  if (from_last[r_tag[IW-1:0]])
                    seen[BW'(e_blk[r_tag[IW-1:0]] % BLOCK_IDS)] <= 1'b1;
                  result_kind <= csb_pkg::RK_FREED;
                end
              end
            end
            csb_pkg::CMD_TICK: begin
              if (!r_ready) begin
                result_valid <= 1'b1;
                tick_count <= tick_count + 1'b1;
              end
            end
            csb_pkg::CMD_DRAIN: begin
              result_valid <= 1'b1;
              drain_active <= 1'b1;
              drain_block <= r_blk;
            end
            default: ;
          endcase
        end
        csb_pkg::ST_ISSUE_OLD: begin
          idx <= '0;
          n_out <= '0;
          hold_f <= 1'b0;
          if (old_f) begin
            waiting[old_i] <= 1'b1;
            n_out <= 5'd1;
            hold_f <= 1'b1;
            hold_idx <= 4'(old_i);
            hold_addr <= e_addr[old_i]; hold_data <= e_data[old_i];
            hold_mask <= e_mask[old_i]; hold_blk <= e_blk[old_i];
          end
        end
        csb_pkg::ST_DRAIN: begin
          idx <= idx + 1'b1;
          if (drain_hit && n_out < 5'd16) begin
            waiting[ci] <= 1'b1;
            n_out <= n_out + 1'b1;
            // A newer issue exists, so the held one is not the last.
            if (hold_f) begin
              result_valid <= 1'b1;
              result_kind <= csb_pkg::RK_ISSUED;
              entry_index <= hold_idx;
              write_address <= hold_addr; write_data <= hold_data;
              write_mask <= hold_mask; result_block <= hold_blk;
              occupancy <= 5'(occ);
              last_of_run <= 1'b0;
            end
            hold_f <= 1'b1;
            hold_idx <= 4'(ci);
            hold_addr <= e_addr[ci]; hold_data <= e_data[ci];
            hold_mask <= e_mask[ci]; hold_blk <= e_blk[ci];
          end
        end
        csb_pkg::ST_DONE: begin
          // Closing result: the held issue if any went out, else an idle marker.
          tick_count <= tick_count + 1'b1;
          result_valid <= 1'b1;
          occupancy <= 5'(occ);
          last_of_run <= 1'b1;
          if (hold_f) begin
            result_kind <= csb_pkg::RK_ISSUED;
            entry_index <= hold_idx;
            write_address <= hold_addr; write_data <= hold_data;
            write_mask <= hold_mask; result_block <= hold_blk;
          end else begin
            result_kind <= csb_pkg::RK_IDLE;
            entry_index <= '0;
            write_address <= '0; write_data <= '0; write_mask <= '0;
            result_block <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== test/coalescing_store_buffer_core_test.sv =====
// Self-checking testbench for the coalescing store buffer core.
module coalescing_store_buffer_core_test;

  localparam int NUM_ENTRIES = 16;
  localparam int NUM_BLOCKS = 256;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_ITEMS = 75;

  // One request as the driver presents it on the input ports.
  typedef struct {
    csb_pkg::cmd_t cmd;
    logic [31:0] addr;
    logic [7:0]  blk;
    logic [63:0] data;
    logic [7:0]  mask;
    logic        last_instr;
    logic [3:0]  tag;
    logic        upstream;
    logic        ready;
  } store_req_t;

  // One result as the block should present it.
  typedef struct {
    csb_pkg::kind_t kind;
    logic [3:0]  idx;
    logic [31:0] addr;
    logic [63:0] data;
    logic [7:0]  mask;
    logic [7:0]  blk;
    logic [4:0]  occ;
    logic        last;
  } buf_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        cfg_write = 1'b0;
  logic        cfg_data = 1'b0;
  logic [1:0]  command = 2'd0;
  logic [31:0] line_address = '0;
  logic [7:0]  block_id = '0;
  logic [63:0] store_data = '0;
  logic [7:0]  byte_mask = '0;
  logic        last_of_instruction = 1'b0;
  logic [3:0]  response_tag = '0;
  logic        upstream_holds_block = 1'b0;
  logic        write_ready = 1'b0;
  logic        result_valid;
  logic [2:0]  result_kind;
  logic [3:0]  entry_index;
  logic [31:0] write_address;
  logic [63:0] write_data;
  logic [7:0]  write_mask;
  logic [7:0]  result_block;
  logic [4:0]  occupancy;
  logic        last_of_run;

  coalescing_store_buffer_core u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cfg_write(cfg_write), .cfg_data(cfg_data),
    .command(command), .line_address(line_address), .block_id(block_id),
    .store_data(store_data), .byte_mask(byte_mask),
    .last_of_instruction(last_of_instruction), .response_tag(response_tag),
    .upstream_holds_block(upstream_holds_block), .write_ready(write_ready),
    .result_valid(result_valid), .result_kind(result_kind),
    .entry_index(entry_index), .write_address(write_address),
    .write_data(write_data), .write_mask(write_mask),
    .result_block(result_block), .occupancy(occupancy), .last_of_run(last_of_run)
  );

  always #5 clk = ~clk;

  // Shadow copy of the buffer state, updated at every accepted request.
  logic        sh_valid [NUM_ENTRIES];
  logic        sh_waiting [NUM_ENTRIES];
  logic        sh_from_last [NUM_ENTRIES];
  logic [31:0] sh_addr [NUM_ENTRIES];
  logic [7:0]  sh_blk [NUM_ENTRIES];
  logic [63:0] sh_data [NUM_ENTRIES];
  logic [7:0]  sh_mask [NUM_ENTRIES];
  logic [31:0] sh_stamp [NUM_ENTRIES];
  logic [31:0] sh_ticks;
  logic        sh_drain_on;
  logic [7:0]  sh_drain_blk;
  logic        sh_seen [NUM_BLOCKS];
  logic        sh_commit_en;

  store_req_t  pending_reqs[$];
  buf_result_t expected_results[$];
  logic [31:0] addr_pool [20];
  logic [7:0]  blk_pool [4];

  bit failed = 0;
  bit req_taken = 1;   // the request currently on the ports has been accepted
  bit quiet = 0;       // no idle bursts in the closing stretch
  int idle_left = 0;
  int stall_cycles = 0;

  function automatic logic [63:0] lane_bits(logic [7:0] m);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < 8; i++)
      if (m[i]) r[8*i +: 8] = 8'hFF;
    return r;
  endfunction

  function automatic buf_result_t make_result(csb_pkg::kind_t k, logic [3:0] i, logic [7:0] b);
    buf_result_t r;
    r.kind = k; r.idx = i; r.addr = '0; r.data = '0; r.mask = '0;
    r.blk = b; r.occ = '0; r.last = 1'b0;
    return r;
  endfunction

  // Marks an entry as sent downstream and builds its write result.
  function automatic buf_result_t send_write(int i);
    buf_result_t r;
    sh_waiting[i] = 1'b1;
    r = make_result(csb_pkg::RK_ISSUED, i[3:0], sh_blk[i]);
    r.addr = sh_addr[i];
    r.data = sh_data[i];
    r.mask = sh_mask[i];
    return r;
  endfunction

  // Applies one accepted request to the shadow state and queues its results.
  task automatic buffer_apply(store_req_t q);
    buf_result_t outs[$];
    int hit, free_slot, oldest, occ;
    logic [31:0] best;
    logic [63:0] dm;
    logic [7:0] b;
    bit others;
    hit = -1; free_slot = -1; oldest = -1;
    case (q.cmd)
      csb_pkg::CMD_STORE: begin
        for (int i = 0; i < NUM_ENTRIES; i++) begin
          if (hit < 0 && sh_valid[i] && sh_addr[i] == q.addr) hit = i;
          if (free_slot < 0 && !sh_valid[i]) free_slot = i;
        end
        if (hit >= 0) begin
          // Merging keeps the entry's own block and its waiting state.
          dm = lane_bits(q.mask);
          sh_data[hit] = (sh_data[hit] & ~dm) | (q.data & dm);
          sh_mask[hit] |= q.mask;
          sh_stamp[hit] = sh_ticks;
          if (q.last_instr) sh_from_last[hit] = 1'b1;
          outs.push_back(make_result(csb_pkg::RK_MERGED, hit[3:0], sh_blk[hit]));
        end else if (free_slot >= 0) begin
          sh_valid[free_slot] = 1'b1;
          sh_waiting[free_slot] = 1'b0;
          sh_addr[free_slot] = q.addr;
          sh_blk[free_slot] = q.blk;
          sh_stamp[free_slot] = sh_ticks;
          sh_mask[free_slot] = q.mask;
          sh_data[free_slot] = q.data;
          sh_from_last[free_slot] = q.last_instr;
          outs.push_back(make_result(csb_pkg::RK_ALLOC, free_slot[3:0], q.blk));
        end else begin
          outs.push_back(make_result(csb_pkg::RK_REFUSED, 4'd0, q.blk));
        end
      end
      csb_pkg::CMD_RESP: begin
        if (sh_valid[q.tag] && sh_waiting[q.tag]) begin
          b = sh_blk[q.tag];
          others = q.upstream;
          for (int i = 0; i < NUM_ENTRIES; i++)
            if (i != q.tag && sh_valid[i] && sh_blk[i] == b) others = 1;
          if (sh_commit_en && !others && (sh_from_last[q.tag] || sh_seen[b])) begin
            sh_seen[b] = 1'b0;
            outs.push_back(make_result(csb_pkg::RK_COMMITTED, q.tag, b));
          end else begin
            if (sh_from_last[q.tag]) sh_seen[b] = 1'b1;
            outs.push_back(make_result(csb_pkg::RK_FREED, q.tag, b));
          end
          sh_valid[q.tag] = 1'b0;
          sh_waiting[q.tag] = 1'b0;
          sh_from_last[q.tag] = 1'b0;
        end else begin
          outs.push_back(make_result(csb_pkg::RK_IDLE, 4'd0, 8'd0));
        end
      end
      csb_pkg::CMD_TICK: begin
        if (q.ready) begin
          // Oldest by stamp, lowest index on a tie; then the drained block.
          best = 32'hFFFF_FFFF;
          for (int i = 0; i < NUM_ENTRIES; i++)
            if (sh_valid[i] && !sh_waiting[i] && sh_stamp[i] < best) begin
              best = sh_stamp[i];
              oldest = i;
            end
          if (oldest >= 0) outs.push_back(send_write(oldest));
          if (sh_drain_on)
            for (int i = 0; i < NUM_ENTRIES; i++)
              if (outs.size() < 16 && sh_valid[i] && !sh_waiting[i]
                  && sh_blk[i] == sh_drain_blk)
                outs.push_back(send_write(i));
        end
        sh_ticks = sh_ticks + 1;
        if (outs.size() == 0) outs.push_back(make_result(csb_pkg::RK_IDLE, 4'd0, 8'd0));
      end
      default: begin
        sh_drain_on = 1'b1;
        sh_drain_blk = q.blk;
        outs.push_back(make_result(csb_pkg::RK_IDLE, 4'd0, 8'd0));
      end
    endcase
    occ = 0;
    for (int i = 0; i < NUM_ENTRIES; i++) occ += int'(sh_valid[i]);
    outs[outs.size() - 1].last = 1'b1;
    foreach (outs[k]) begin
      outs[k].occ = occ[4:0];
      expected_results.push_back(outs[k]);
    end
  endtask

  function automatic store_req_t blank_req(csb_pkg::cmd_t c);
    store_req_t q;
    q.cmd = c; q.addr = '0; q.blk = '0; q.data = '0; q.mask = '0;
    q.last_instr = 0; q.tag = '0; q.upstream = 0; q.ready = 0;
    return q;
  endfunction

  function automatic store_req_t store_req(logic [31:0] a, logic [7:0] b, logic [63:0] d,
                                           logic [7:0] m, logic l);
    store_req_t q;
    q = blank_req(csb_pkg::CMD_STORE);
    q.addr = a; q.blk = b; q.data = d; q.mask = m; q.last_instr = l;
    return q;
  endfunction

  // Mostly well-formed traffic on a small address and block pool, plus noise.
  function automatic store_req_t random_req();
    store_req_t q;
    int pick, waiting_tags[$];
    pick = $urandom_range(0, 99);
    q = blank_req(csb_pkg::CMD_STORE);
    q.data = {$urandom, $urandom};
    q.mask = 8'($urandom);
    q.last_instr = 1'($urandom);
    q.addr = ($urandom_range(0, 4) == 0) ? $urandom : addr_pool[$urandom_range(0, 19)];
    q.blk = ($urandom_range(0, 5) == 0) ? 8'($urandom) : blk_pool[$urandom_range(0, 3)];
    if (pick < 45) begin
      q.cmd = csb_pkg::CMD_STORE;
    end else if (pick < 70) begin
      q.cmd = csb_pkg::CMD_TICK;
      q.ready = ($urandom_range(0, 6) != 0);
    end else if (pick < 90) begin
      q.cmd = csb_pkg::CMD_RESP;
      for (int i = 0; i < NUM_ENTRIES; i++)
        if (sh_valid[i] && sh_waiting[i]) waiting_tags.push_back(i);
      if (waiting_tags.size() > 0 && $urandom_range(0, 9) != 0)
        q.tag = 4'(waiting_tags[$urandom_range(0, waiting_tags.size() - 1)]);
      else
        q.tag = 4'($urandom);
      q.upstream = ($urandom_range(0, 3) == 0);
    end else if (pick < 95) begin
      q.cmd = csb_pkg::CMD_DRAIN;
    end else begin
      q.cmd = csb_pkg::cmd_t'($urandom_range(0, 3));
      q.addr = $urandom;
      q.blk = 8'($urandom);
      q.tag = 4'($urandom);
      q.upstream = 1'($urandom);
      q.ready = 1'($urandom);
    end
    return q;
  endfunction

  // Driver: presents pending requests at the falling edge, with random idle bursts.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !req_taken) begin
      start <= 1'b1;
    end else if (idle_left > 0) begin
      idle_left--;
      start <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      idle_left = $urandom_range(0, 4);
      start <= 1'b0;
    end else if (pending_reqs.size() > 0) begin
      store_req_t q;
      q = pending_reqs[0];
      pending_reqs.delete(0);
      command <= q.cmd;
      line_address <= q.addr;
      block_id <= q.blk;
      store_data <= q.data;
      byte_mask <= q.mask;
      last_of_instruction <= q.last_instr;
      response_tag <= q.tag;
      upstream_holds_block <= q.upstream;
      write_ready <= q.ready;
      req_taken = 0;
      start <= 1'b1;
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: tracks accepted requests and config writes, checks each result strobe.
  always @(posedge clk) begin
    if (!rst) begin
      stall_cycles++;
      if (cfg_write) sh_commit_en = cfg_data;
      if (result_valid) begin
        buf_result_t e;
        stall_cycles = 0;
        if (expected_results.size() == 0) begin
          $error("unexpected result kind %0d entry %0d", result_kind, entry_index);
          failed = 1;
        end else begin
          e = expected_results[0];
          expected_results.delete(0);
          if (result_kind !== e.kind) begin
            $error("result_kind expected %0d actual %0d", e.kind, result_kind);
            failed = 1;
          end
          if (entry_index !== e.idx) begin
            $error("entry_index expected %0d actual %0d", e.idx, entry_index);
            failed = 1;
          end
          if (write_address !== e.addr) begin
            $error("write_address expected %h actual %h", e.addr, write_address);
            failed = 1;
          end
          if (write_data !== e.data) begin
            $error("write_data expected %h actual %h", e.data, write_data);
            failed = 1;
          end
          if (write_mask !== e.mask) begin
            $error("write_mask expected %h actual %h", e.mask, write_mask);
            failed = 1;
          end
          if (result_block !== e.blk) begin
            $error("result_block expected %0d actual %0d", e.blk, result_block);
            failed = 1;
          end
          if (occupancy !== e.occ) begin
            $error("occupancy expected %0d actual %0d", e.occ, occupancy);
            failed = 1;
          end
          if (last_of_run !== e.last) begin
            $error("last_of_run expected %0d actual %0d", e.last, last_of_run);
            failed = 1;
          end
        end
      end
      // A request is taken at an edge where start is high and busy is low.
      if (start && !busy && !req_taken) begin
        req_taken = 1;
        stall_cycles = 0;
        buffer_apply('{csb_pkg::cmd_t'(command), line_address, block_id, store_data,
                       byte_mask, last_of_instruction, response_tag,
                       upstream_holds_block, write_ready});
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Blocks until every queued request is taken and every result has been seen.
  task automatic wait_drained();
    while (pending_reqs.size() > 0 || !req_taken || expected_results.size() > 0 || busy)
      @(negedge clk);
  endtask

  // Lazily feeds one request at a time so responses can name live waiting entries.
  task automatic feed(store_req_t q);
    while (pending_reqs.size() > 0) @(negedge clk);
    pending_reqs.push_back(q);
  endtask

  task automatic write_commit_enable(logic v);
    wait_drained();
    repeat (20) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    store_req_t q;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      sh_valid[i] = 0; sh_waiting[i] = 0; sh_from_last[i] = 0;
      sh_addr[i] = '0; sh_blk[i] = '0; sh_data[i] = '0; sh_mask[i] = '0; sh_stamp[i] = '0;
    end
    for (int i = 0; i < NUM_BLOCKS; i++) sh_seen[i] = 0;
    sh_ticks = '0; sh_drain_on = 0; sh_drain_blk = '0; sh_commit_en = 1;
    foreach (addr_pool[i]) addr_pool[i] = (i < 2) ? {32{i[0]}} : $urandom;
    foreach (blk_pool[i]) blk_pool[i] = (i == 0) ? 8'hFF : 8'($urandom);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: lane extremes, merging across blocks and into a waiting entry,
    // write-not-ready, drain, stray and committing responses, then a full buffer.
    feed(store_req(32'h0, 8'h00, '1, 8'hFF, 1'b0));
    feed(store_req(32'hFFFF_FFFF, 8'hFF, '0, 8'h00, 1'b1));
    feed(store_req(32'h0, 8'h07, 64'h5555_5555_5555_5555, 8'h0F, 1'b1));
    q = blank_req(csb_pkg::CMD_TICK); feed(q);
    q.ready = 1; feed(q);
    feed(store_req(32'h0, 8'h09, 64'hAAAA_AAAA_AAAA_AAAA, 8'hF0, 1'b0));
    q = blank_req(csb_pkg::CMD_DRAIN); q.blk = 8'hFF; feed(q);
    q = blank_req(csb_pkg::CMD_TICK); q.ready = 1; feed(q);
    q = blank_req(csb_pkg::CMD_RESP); q.tag = 4'd0; q.upstream = 1; feed(q);
    q.upstream = 0; feed(q);
    q.tag = 4'd1; feed(q);
    q.tag = 4'd15; feed(q);
    for (int i = 0; i < 17; i++)
      feed(store_req(32'h100 + i, 8'h03, {$urandom, $urandom}, 8'($urandom), i[0]));
    q = blank_req(csb_pkg::CMD_DRAIN); q.blk = 8'h03; feed(q);
    q = blank_req(csb_pkg::CMD_TICK); q.ready = 1; feed(q);

    // Random phases under alternating commit reporting; each boundary lets the
    // buffer go fully quiet before the register is rewritten.
    for (int phase = 0; phase < 4; phase++) begin
      if (phase > 0) write_commit_enable(phase[0] ? 1'b0 : 1'b1);
      if (phase == 3) quiet = 1;
      for (int n = 0; n < PHASE_ITEMS; n++) feed(random_req());
    end

    wait_drained();
    repeat (40) @(negedge clk);
    if (!failed && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
